[rtl/tbpo_pkg.sv]
// Shared types, constants and helper functions for the triangle clip outline block.
`default_nettype none

package tbpo_pkg;

  // Default coordinate width (signed Q16.16).
  localparam int unsigned CoordWidth = 32;
  // Scale factor is unsigned Q8.8.
  localparam int unsigned ScaleWidth = 16;
  localparam int unsigned ScaleFrac = 8;
  localparam logic [ScaleWidth-1:0] ScaleReset = 16'd256;
  // Configuration register index width.
  localparam int unsigned CfgIdxWidth = 8;
  // Depth of the queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;
  // Up to six outline points per triangle.
  localparam int unsigned MaxPoints = 6;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_Z_CUT    = 8'd0,
    CFG_XY_SCALE = 8'd1
  } cfg_reg_e;

  // Point sources: a vertex, or the crossing point on the edge that starts at a vertex.
  typedef enum logic [2:0] {
    PT_V0 = 3'd0,
    PT_V1 = 3'd1,
    PT_V2 = 3'd2,
    PT_X0 = 3'd3,
    PT_X1 = 3'd4,
    PT_X2 = 3'd5
  } pt_code_e;

  // Classification of one triangle, handed from the front to the back end.
  typedef struct packed {
    logic [2:0]                 lo;
    logic [2:0]                 n;
    logic [MaxPoints-1:0][2:0]  code;
  } clip_plan_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCALE,
    BK_CMP,
    BK_EMIT
  } back_state_e;

  function automatic pt_code_e vert_code(input logic [1:0] k);
    unique case (k)
      2'd0:    return PT_V0;
      2'd1:    return PT_V1;
      2'd2:    return PT_V2;
      default: return PT_V0;
    endcase
  endfunction

  function automatic pt_code_e cross_code(input logic [1:0] k);
    unique case (k)
      2'd0:    return PT_X0;
      2'd1:    return PT_X1;
      2'd2:    return PT_X2;
      default: return PT_X0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/tbpo_if.sv]
// Valid/ready channel interfaces for triangles, segments and configuration writes.
`default_nettype none

interface tbpo_tri_if #(
  parameter int unsigned W = tbpo_pkg::CoordWidth
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ax;
  logic signed [W-1:0] ay;
  logic signed [W-1:0] az;
  logic signed [W-1:0] bx;
  logic signed [W-1:0] by_coord;
  logic signed [W-1:0] bz;
  logic signed [W-1:0] cx;
  logic signed [W-1:0] cy;
  logic signed [W-1:0] cz;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tbpo_seg_if #(
  parameter int unsigned W = tbpo_pkg::CoordWidth
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic                last_segment;

  modport source (output valid, start_x, start_y, end_x, end_y, last_segment, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, last_segment, output ready);
endinterface

interface tbpo_cfg_if #(
  parameter int unsigned W = tbpo_pkg::CoordWidth
);
  logic                                valid;
  logic                                ready;
  logic [tbpo_pkg::CfgIdxWidth-1:0]    index;
  logic [W-1:0]                        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/tbpo_front.sv]
// Front end: accepts triangles, classifies the vertices and plans the outline point list.
`default_nettype none

module tbpo_front #(
  parameter int unsigned W    = tbpo_pkg::CoordWidth,
  parameter int unsigned EntW = 9 * W + $bits(tbpo_pkg::clip_plan_t)
) (
  tbpo_tri_if.sink            tri_i,
  input  logic signed [W-1:0] z_cut_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output logic [EntW-1:0]     push_data_o
);

  logic [2:0]           lo;
  tbpo_pkg::clip_plan_t plan;

  // A vertex is kept when it lies at or below the cut.
  assign lo[0] = tri_i.az <= z_cut_i;
  assign lo[1] = tri_i.bz <= z_cut_i;
  assign lo[2] = tri_i.cz <= z_cut_i;

  // Walk each edge of the triangle in turn and list where each outline point comes from.
  always_comb begin
    logic [2:0] cnt;
    logic [1:0] j;
    plan = '0;
    cnt  = '0;
    for (int e = 0; e < 3; e++) begin
      j = (e == 2) ? 2'd0 : 2'(e + 1);
      if (lo[e]) begin
        plan.code[cnt] = tbpo_pkg::vert_code(2'(e));
        cnt = cnt + 3'd1;
      end
      if (lo[e] != lo[j]) begin
        plan.code[cnt] = tbpo_pkg::cross_code(2'(e));
        cnt = cnt + 3'd1;
      end
      if (lo[j]) begin
        plan.code[cnt] = tbpo_pkg::vert_code(j);
        cnt = cnt + 3'd1;
      end
    end
    plan.lo = lo;
    plan.n  = cnt;
  end

  assign push_valid_o = tri_i.valid;
  assign tri_i.ready  = push_ready_i;
  assign push_data_o  = {plan, tri_i.cz, tri_i.cy, tri_i.cx, tri_i.bz, tri_i.by_coord,
                         tri_i.bx, tri_i.az, tri_i.ay, tri_i.ax};

endmodule

`default_nettype wire

[rtl/tbpo_fifo.sv]
// Small request queue between the front and the back end.
`default_nettype none

module tbpo_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = tbpo_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/tbpo_muldiv.sv]
// Bit-serial unit that computes floor(a * b / d) for b <= d, one bit of a per cycle.
`default_nettype none

module tbpo_muldiv #(
  parameter int unsigned N = tbpo_pkg::CoordWidth + 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] a_i,
  input  logic [N-1:0] b_i,
  input  logic [N-1:0] d_i,
  output logic         done_o,
  output logic [N-1:0] q_o
);

  localparam int unsigned CntW = $clog2(N + 1);

  logic [N-1:0]    a_q, b_q, d_q, rem_q, quot_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [N+1:0]    t0, t1, t2;
  logic            k1, k2;
  logic [N-1:0]    rem_d, quot_d;

  // One step: remainder doubles, adds b when the bit of a is set, then at most two subtracts.
  always_comb begin
    t0 = {1'b0, rem_q, 1'b0} + (a_q[N-1] ? {2'b00, b_q} : '0);
    k1 = t0 >= {2'b00, d_q};
    t1 = k1 ? t0 - {2'b00, d_q} : t0;
    k2 = t1 >= {2'b00, d_q};
    t2 = k2 ? t1 - {2'b00, d_q} : t1;
    rem_d  = t2[N-1:0];
    quot_d = {quot_q[N-2:0], 1'b0} + N'(k1) + N'(k2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(N);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      d_q    <= d_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (run_q) begin
      a_q    <= {a_q[N-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign q_o    = quot_q;

endmodule

`default_nettype wire

[rtl/tbpo_back.sv]
// Back end: computes crossing points, scales the outline and emits its nonzero segments.
`default_nettype none

module tbpo_back #(
  parameter int unsigned W    = tbpo_pkg::CoordWidth,
  parameter int unsigned EntW = 9 * W + $bits(tbpo_pkg::clip_plan_t)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  logic [EntW-1:0]                     pop_data_i,
  input  logic signed [W-1:0]                 z_cut_i,
  input  logic [tbpo_pkg::ScaleWidth-1:0]     xy_scale_i,
  tbpo_seg_if.source                          seg_o
);

  localparam int unsigned PlanW = $bits(tbpo_pkg::clip_plan_t);
  localparam int unsigned PW    = W + tbpo_pkg::ScaleWidth + 1;
  localparam int unsigned NP    = tbpo_pkg::MaxPoints;

  tbpo_pkg::back_state_e state_q, state_d;
  tbpo_pkg::clip_plan_t  plan_q;
  logic [9*W-1:0]        ent_q;
  logic [1:0]            edge_q;
  logic                  run_q;
  logic signed [W-1:0]   xr_q [3];
  logic signed [W-1:0]   yr_q [3];
  logic [2:0]            sidx_q, widx_q, rem_q;
  logic                  pv_q;
  logic signed [PW-1:0]  prodx_q, prody_q;
  logic signed [W-1:0]   lx_q [NP];
  logic signed [W-1:0]   ly_q [NP];
  logic signed [W-1:0]   fx_q, fy_q;
  logic [NP-1:0]         diff_q, diff_d;
  logic                  ovalid_q;
  logic signed [W-1:0]   osx_q, osy_q, oex_q, oey_q;
  logic                  olast_q;

  logic signed [W-1:0] vx [3];
  logic signed [W-1:0] vy [3];
  logic signed [W-1:0] vz [3];

  for (genvar k = 0; k < 3; k++) begin : g_vert
    assign vx[k] = ent_q[(3*k)*W +: W];
    assign vy[k] = ent_q[(3*k+1)*W +: W];
    assign vz[k] = ent_q[(3*k+2)*W +: W];
  end

  function automatic logic [W:0] mag(input logic [W:0] v);
    return v[W] ? (~v + (W+1)'(1)) : v;
  endfunction

  // Edge operands for the crossing computation.
  logic signed [W-1:0] p1x, p2x, p1y, p2y, z1, z2;
  logic                lo1, lo2, cross_e;
  logic [W:0]          dx, dy, bmag, dmag;
  logic [W:0]          qx, qy;
  logic                xdone, ydone;
  logic                div_start;
  logic signed [W-1:0] crx, cry;

  always_comb begin
    unique case (edge_q)
      2'd1: begin
        p1x = vx[1]; p2x = vx[2]; p1y = vy[1]; p2y = vy[2]; z1 = vz[1]; z2 = vz[2];
        lo1 = plan_q.lo[1]; lo2 = plan_q.lo[2];
      end
      2'd2: begin
        p1x = vx[2]; p2x = vx[0]; p1y = vy[2]; p2y = vy[0]; z1 = vz[2]; z2 = vz[0];
        lo1 = plan_q.lo[2]; lo2 = plan_q.lo[0];
      end
      default: begin
        p1x = vx[0]; p2x = vx[1]; p1y = vy[0]; p2y = vy[1]; z1 = vz[0]; z2 = vz[1];
        lo1 = plan_q.lo[0]; lo2 = plan_q.lo[1];
      end
    endcase
    cross_e = lo1 != lo2;
    dx   = {p2x[W-1], p2x} - {p1x[W-1], p1x};
    dy   = {p2y[W-1], p2y} - {p1y[W-1], p1y};
    bmag = mag({z_cut_i[W-1], z_cut_i} - {z1[W-1], z1});
    dmag = mag({z2[W-1], z2} - {z1[W-1], z1});
  end

  assign div_start = (state_q == tbpo_pkg::BK_DIV) && cross_e && !run_q;

  tbpo_muldiv #(.N(W + 1)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (mag(dx)),
    .b_i     (bmag),
    .d_i     (dmag),
    .done_o  (xdone),
    .q_o     (qx)
  );

  tbpo_muldiv #(.N(W + 1)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (mag(dy)),
    .b_i     (bmag),
    .d_i     (dmag),
    .done_o  (ydone),
    .q_o     (qy)
  );

  // Crossing point lies between the two end points, so the low bits are exact.
  logic [W:0] crx_w, cry_w;
  assign crx_w = dx[W] ? {p1x[W-1], p1x} - qx : {p1x[W-1], p1x} + qx;
  assign cry_w = dy[W] ? {p1y[W-1], p1y} - qy : {p1y[W-1], p1y} + qy;
  assign crx   = crx_w[W-1:0];
  assign cry   = cry_w[W-1:0];

  // Raw point selected by the plan for the scale step.
  logic signed [W-1:0]  rawx, rawy;
  logic signed [PW-1:0] prodx_d, prody_d;
  logic [2:0]           scode;

  always_comb begin
    scode = plan_q.code[sidx_q];
    unique case (tbpo_pkg::pt_code_e'(scode))
      tbpo_pkg::PT_V1: begin rawx = vx[1];   rawy = vy[1];   end
      tbpo_pkg::PT_V2: begin rawx = vx[2];   rawy = vy[2];   end
      tbpo_pkg::PT_X0: begin rawx = xr_q[0]; rawy = yr_q[0]; end
      tbpo_pkg::PT_X1: begin rawx = xr_q[1]; rawy = yr_q[1]; end
      tbpo_pkg::PT_X2: begin rawx = xr_q[2]; rawy = yr_q[2]; end
      default:         begin rawx = vx[0];   rawy = vy[0];   end
    endcase
    prodx_d = rawx * $signed({1'b0, xy_scale_i});
    prody_d = rawy * $signed({1'b0, xy_scale_i});
  end

  // Floor shift by the fraction bits, then saturate to the coordinate range.
  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    logic [PW-W:0]        hi;
    sh = p >>> tbpo_pkg::ScaleFrac;
    hi = sh[PW-1:W-1];
    if ((&hi) || !(|hi)) begin
      return sh[W-1:0];
    end
    return sh[PW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // Each listed point against its successor, the last one closing back to the first.
  always_comb begin
    int j;
    diff_d = '0;
    for (int i = 0; i < NP; i++) begin
      j = (i == NP - 1) ? 0 : i + 1;
      if (3'(i) < plan_q.n) begin
        if (3'(i + 1) == plan_q.n) begin
          diff_d[i] = (lx_q[i] != lx_q[0]) || (ly_q[i] != ly_q[0]);
        end else begin
          diff_d[i] = (lx_q[i] != lx_q[j]) || (ly_q[i] != ly_q[j]);
        end
      end
    end
  end

  logic out_free, emit_go, out_load;
  assign out_free = !ovalid_q || seg_o.ready;
  assign emit_go  = (state_q == tbpo_pkg::BK_EMIT) && (!diff_q[0] || out_free);
  assign out_load = (state_q == tbpo_pkg::BK_EMIT) && diff_q[0] && out_free;

  assign pop_ready_o = state_q == tbpo_pkg::BK_IDLE;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tbpo_pkg::BK_IDLE: begin
        if (pop_valid_i && (pop_data_i[EntW-1 -: PlanW] >> (NP * 3)) != '0) begin
          state_d = tbpo_pkg::BK_DIV;
        end
      end
      tbpo_pkg::BK_DIV: begin
        if ((!cross_e || (run_q && xdone)) && edge_q == 2'd2) begin
          state_d = tbpo_pkg::BK_SCALE;
        end
      end
      tbpo_pkg::BK_SCALE: begin
        if (sidx_q == plan_q.n) begin
          state_d = tbpo_pkg::BK_CMP;
        end
      end
      tbpo_pkg::BK_CMP: begin
        state_d = tbpo_pkg::BK_EMIT;
      end
      tbpo_pkg::BK_EMIT: begin
        if (emit_go && rem_q == 3'd1) begin
          state_d = tbpo_pkg::BK_IDLE;
        end
      end
      default: state_d = tbpo_pkg::BK_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tbpo_pkg::BK_IDLE;
      edge_q   <= '0;
      run_q    <= 1'b0;
      sidx_q   <= '0;
      pv_q     <= 1'b0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == tbpo_pkg::BK_SCALE) && (sidx_q != plan_q.n);
      if (state_q == tbpo_pkg::BK_IDLE) begin
        edge_q <= '0;
        run_q  <= 1'b0;
        sidx_q <= '0;
      end
      if (div_start) begin
        run_q <= 1'b1;
      end
      if (state_q == tbpo_pkg::BK_DIV && (!cross_e || (run_q && xdone))) begin
        run_q  <= 1'b0;
        edge_q <= edge_q + 2'd1;
      end
      if (state_q == tbpo_pkg::BK_SCALE && sidx_q != plan_q.n) begin
        sidx_q <= sidx_q + 3'd1;
      end
      if (state_q == tbpo_pkg::BK_CMP) begin
        rem_q <= plan_q.n;
      end
      if (emit_go) begin
        rem_q <= rem_q - 3'd1;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (seg_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      ent_q  <= pop_data_i[9*W-1:0];
      plan_q <= pop_data_i[EntW-1 -: PlanW];
    end
    if (state_q == tbpo_pkg::BK_DIV && cross_e && run_q && xdone && ydone) begin
      xr_q[edge_q] <= crx;
      yr_q[edge_q] <= cry;
    end
    prodx_q <= prodx_d;
    prody_q <= prody_d;
    widx_q  <= sidx_q;
    if (pv_q) begin
      lx_q[widx_q] <= sat(prodx_q);
      ly_q[widx_q] <= sat(prody_q);
    end
    if (state_q == tbpo_pkg::BK_CMP) begin
      diff_q <= diff_d;
      fx_q   <= lx_q[0];
      fy_q   <= ly_q[0];
    end
    if (emit_go) begin
      for (int k = 0; k < NP - 1; k++) begin
        lx_q[k] <= lx_q[k+1];
        ly_q[k] <= ly_q[k+1];
      end
      diff_q <= {1'b0, diff_q[NP-1:1]};
    end
    if (out_load) begin
      osx_q   <= lx_q[0];
      osy_q   <= ly_q[0];
      oex_q   <= (rem_q == 3'd1) ? fx_q : lx_q[1];
      oey_q   <= (rem_q == 3'd1) ? fy_q : ly_q[1];
      olast_q <= diff_q[NP-1:1] == '0;
    end
  end

  assign seg_o.valid        = ovalid_q;
  assign seg_o.start_x      = osx_q;
  assign seg_o.start_y      = osy_q;
  assign seg_o.end_x        = oex_q;
  assign seg_o.end_y        = oey_q;
  assign seg_o.last_segment = olast_q;

endmodule

`default_nettype wire

[rtl/triangle_below_plane_outline.sv]
// Top level: clips a triangle to z <= cut and emits the scaled XY outline segments.
// Each crossing edge waits on the bit-serial multiply-divide units for x and y.
// The back end handles one triangle at a time; a two-entry queue takes triangles while the
// back end works, and output stalls hold the back end.
// Reset is asynchronous and active low: z_cut clears to 0 and xy_scale to 1.0 at once.
`default_nettype none

module triangle_below_plane_outline #(
  parameter int unsigned COORD_WIDTH = tbpo_pkg::CoordWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbpo_tri_if.sink   tri_i,
  tbpo_seg_if.source seg_o,
  tbpo_cfg_if.sink   cfg_i
);

  localparam int unsigned EntW = 9 * COORD_WIDTH + $bits(tbpo_pkg::clip_plan_t);

  logic signed [COORD_WIDTH-1:0]       z_cut_q;
  logic [tbpo_pkg::ScaleWidth-1:0]     xy_scale_q;
  logic                                push_valid, push_ready, pop_valid, pop_ready;
  logic [EntW-1:0]                     push_data, pop_data;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_cut_q    <= '0;
      xy_scale_q <= tbpo_pkg::ScaleReset;
    end else if (cfg_i.valid) begin
      case (tbpo_pkg::cfg_reg_e'(cfg_i.index))
        tbpo_pkg::CFG_Z_CUT:    z_cut_q    <= cfg_i.data[COORD_WIDTH-1:0];
        tbpo_pkg::CFG_XY_SCALE: xy_scale_q <= cfg_i.data[tbpo_pkg::ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  tbpo_front #(.W(COORD_WIDTH), .EntW(EntW)) u_front (
    .tri_i        (tri_i),
    .z_cut_i      (z_cut_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tbpo_fifo #(.Width(EntW), .Depth(tbpo_pkg::QueueDepth)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tbpo_back #(.W(COORD_WIDTH), .EntW(EntW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .z_cut_i     (z_cut_q),
    .xy_scale_i  (xy_scale_q),
    .seg_o       (seg_o)
  );

endmodule

`default_nettype wire

[rtl/tbpo_checker.sv]
// Port-level checks on the segment output, bound to the top level.
`default_nettype none

module tbpo_checker #(
  parameter int unsigned W = tbpo_pkg::CoordWidth
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_i,
  input logic                ready_i,
  input logic signed [W-1:0] start_x_i,
  input logic signed [W-1:0] start_y_i,
  input logic signed [W-1:0] end_x_i,
  input logic signed [W-1:0] end_y_i,
  input logic                last_i
);

  logic signed [W-1:0] prev_x_q, prev_y_q;
  logic                open_q;

  // Track the end of the last segment of a triangle whose outline is still open.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (valid_i && ready_i) begin
      open_q   <= !last_i;
      prev_x_q <= end_x_i;
      prev_y_q <= end_y_i;
    end
  end

  // A stalled segment holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable({start_x_i, start_y_i, end_x_i, end_y_i, last_i}))
    else $error("segment changed while stalled");

  // Zero-length segments are never emitted.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (start_x_i != end_x_i) || (start_y_i != end_y_i))
    else $error("zero-length segment emitted");

  // Within one outline each segment starts where the previous one ended.
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && open_q |-> (start_x_i == prev_x_q) && (start_y_i == prev_y_q))
    else $error("outline is not continuous");

endmodule

bind triangle_below_plane_outline tbpo_checker #(.W(COORD_WIDTH)) u_tbpo_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (seg_o.valid),
  .ready_i   (seg_o.ready),
  .start_x_i (seg_o.start_x),
  .start_y_i (seg_o.start_y),
  .end_x_i   (seg_o.end_x),
  .end_y_i   (seg_o.end_y),
  .last_i    (seg_o.last_segment)
);

`default_nettype wire
